/* rtl/lbs_pkg.sv */
// Package with constants, codes and state type for the length-bucketed word store.
`default_nettype none
package lbs_pkg;
	localparam int STORE_BYTES = 64 * 1024;
	localparam int MAX_WORD    = 20;
	localparam int MIN_WORD    = 2;
	localparam int NBUCKETS    = MAX_WORD - MIN_WORD + 1;
	localparam int HDR_BYTES   = NBUCKETS * 2;
	localparam int ADDR_W      = $clog2(STORE_BYTES);
	localparam int POS_W       = ADDR_W + 1;
	localparam int BKT_W       = $clog2(NBUCKETS + 1);
	localparam int CNT_W       = 16;
	localparam int CHAR_W      = 8 * 20;

	typedef enum logic [2:0] {
		REQ_ADD      = 3'd0,
		REQ_REMOVE   = 3'd1,
		REQ_CONTAINS = 3'd2,
		REQ_INDEX    = 3'd3,
		REQ_CLEAR    = 3'd4
	} req_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_ABSENT = 2'd1,
		ST_FULL   = 2'd2,
		ST_BADLEN = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE, S_LOAD_E, S_FIND_RD, S_FIND_CMP, S_INS_RD, S_INS_WR, S_PUT,
		S_DEL_RD, S_DEL_WR, S_IDX_WALK, S_IDX_RD, S_IDX_CAP, S_DONE
	} state_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [7:0]        wdata;
		logic [ADDR_W-1:0] raddr;
	} ram_ctl_t;
endpackage
`default_nettype wire

/* rtl/lbs_byte_ram.sv */
// Byte store RAM: one write and one registered read per cycle.
`default_nettype none
module lbs_byte_ram (
	input  wire logic             clk,
	input  wire lbs_pkg::ram_ctl_t ctl,
	output logic [7:0]            rdata
);
	logic [7:0] mem [lbs_pkg::STORE_BYTES];

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[ctl.waddr] <= ctl.wdata;
		end
		rdata <= mem[ctl.raddr];
	end
endmodule
`default_nettype wire

/* rtl/length_bucketed_sorted_word_store_top.sv */
// Top level of the length-bucketed sorted word store.
//
// channel  direction  handshake            payload
// request  in         in_valid / in_ready  req_type word_length chars_* word_index
// result   out        out_valid/out_ready  status out_length out_chars_* word_total
//
// One request at a time. Each byte compare reads the byte RAM (S_FIND_RD) and then compares the
// registered byte (S_FIND_CMP); add and remove then move every byte behind the slot, a RAM read
// and a write per byte, and add then writes the word in byte by byte (S_PUT).
// Index requests walk the buckets one a cycle, then read each byte (S_IDX_RD, S_IDX_CAP).
// Reset clears the bucket table and counts; the byte RAM needs no clearing pass.
// A pending result is held in the output register while the next request runs.
`default_nettype none
module length_bucketed_sorted_word_store_top (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic [2:0]   req_type,
	input  wire logic [4:0]   word_length,
	input  wire logic [63:0]  chars_low,
	input  wire logic [63:0]  chars_mid,
	input  wire logic [31:0]  chars_high,
	input  wire logic [15:0]  word_index,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic [1:0]        status,
	output logic [4:0]        out_length,
	output logic [63:0]       out_chars_low,
	output logic [63:0]       out_chars_mid,
	output logic [31:0]       out_chars_high,
	output logic [15:0]       word_total
);
	localparam int PW = lbs_pkg::POS_W;
	localparam int AW = lbs_pkg::ADDR_W;
	localparam int BW = lbs_pkg::BKT_W;
	localparam int NB = lbs_pkg::NBUCKETS;
	localparam int CW = lbs_pkg::CNT_W;

	lbs_pkg::state_t  state_q, state_d;
	lbs_pkg::ram_ctl_t ram_ctl;
	logic [7:0]       rdata;

	logic [PW-1:0]    bs_q [NB+1];
	logic [CW-1:0]    cnt_q [NB];
	logic [CW-1:0]    total_q;

	logic [2:0]       req_q;
	logic [4:0]       len_q;
	logic [BW-1:0]    b_q;
	logic [BW-1:0]    k_q;
	logic [lbs_pkg::CHAR_W-1:0] w_q, oc_q;
	logic [CW-1:0]    rem_q;
	logic [PW-1:0]    p_q, e_q, a_q;
	logic [4:0]       i_q, olen_q;
	logic [1:0]       st_q;

	logic             len_ok, in_fire, out_free;
	logic [7:0]       wbyte;
	logic [4:0]       len_m1;
	logic [PW-1:0]    end_pos;
	logic [PW-1:0]    bs_rd;
	logic [BW-1:0]    bs_idx;

	lbs_byte_ram u_ram (
		.clk   (clk),
		.ctl   (ram_ctl),
		.rdata (rdata)
	);

	assign len_ok   = (word_length >= 5'(lbs_pkg::MIN_WORD))
	               && (word_length <= 5'(lbs_pkg::MAX_WORD));
	assign in_ready = (state_q == lbs_pkg::S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid || out_ready;
	assign wbyte    = w_q[{i_q, 3'b000} +: 8];
	assign len_m1   = len_q - 5'd1;
	assign end_pos  = bs_q[NB];
	assign bs_idx   = (state_q == lbs_pkg::S_IDLE) ? BW'(word_length - 5'(lbs_pkg::MIN_WORD))
	                : (state_q == lbs_pkg::S_LOAD_E) ? b_q + BW'(1) : k_q;
	assign bs_rd    = bs_q[bs_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lbs_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and RAM control
	always_comb begin
		state_d       = state_q;
		ram_ctl.we    = 1'b0;
		ram_ctl.waddr = a_q[AW-1:0];
		ram_ctl.wdata = rdata;
		ram_ctl.raddr = p_q[AW-1:0];
		case (state_q)
			lbs_pkg::S_IDLE: begin
				if (in_fire) begin
					if (req_type <= lbs_pkg::REQ_CONTAINS && !len_ok) begin
						state_d = lbs_pkg::S_DONE;
					end else if (req_type <= lbs_pkg::REQ_CONTAINS) begin
						state_d = lbs_pkg::S_LOAD_E;
					end else if (req_type == lbs_pkg::REQ_INDEX) begin
						state_d = lbs_pkg::S_IDX_WALK;
					end else begin
						state_d = lbs_pkg::S_DONE;
					end
				end
			end
			lbs_pkg::S_LOAD_E: state_d = lbs_pkg::S_FIND_RD;
			lbs_pkg::S_FIND_RD: begin
				ram_ctl.raddr = AW'(p_q + PW'(i_q));
				if (p_q >= e_q) begin
					if (req_q == lbs_pkg::REQ_ADD
					    && (end_pos + PW'(len_q)) <= PW'(lbs_pkg::STORE_BYTES)) begin
						state_d = (end_pos > p_q) ? lbs_pkg::S_INS_RD : lbs_pkg::S_PUT;
					end else begin
						state_d = lbs_pkg::S_DONE;
					end
				end else begin
					state_d = lbs_pkg::S_FIND_CMP;
				end
			end
			lbs_pkg::S_FIND_CMP: begin
				if (rdata == wbyte) begin
					if (i_q == len_m1) begin
						if (req_q == lbs_pkg::REQ_REMOVE && (p_q + PW'(len_q)) < end_pos) begin
							state_d = lbs_pkg::S_DEL_RD;
						end else begin
							state_d = lbs_pkg::S_DONE;
						end
					end else begin
						state_d = lbs_pkg::S_FIND_RD;
					end
				end else if (rdata > wbyte) begin
					if (req_q == lbs_pkg::REQ_ADD
					    && (end_pos + PW'(len_q)) <= PW'(lbs_pkg::STORE_BYTES)) begin
						state_d = lbs_pkg::S_INS_RD;
					end else begin
						state_d = lbs_pkg::S_DONE;
					end
				end else begin
					state_d = lbs_pkg::S_FIND_RD;
				end
			end
			lbs_pkg::S_INS_RD: begin
				ram_ctl.raddr = AW'(a_q - PW'(1));
				state_d       = lbs_pkg::S_INS_WR;
			end
			lbs_pkg::S_INS_WR: begin
				ram_ctl.we    = 1'b1;
				ram_ctl.waddr = AW'(a_q - PW'(1) + PW'(len_q));
				state_d = ((a_q - PW'(1)) == p_q) ? lbs_pkg::S_PUT : lbs_pkg::S_INS_RD;
			end
			lbs_pkg::S_PUT: begin
				ram_ctl.we    = 1'b1;
				ram_ctl.waddr = AW'(p_q + PW'(i_q));
				ram_ctl.wdata = wbyte;
				if (i_q == len_m1) begin
					state_d = lbs_pkg::S_DONE;
				end
			end
			lbs_pkg::S_DEL_RD: begin
				ram_ctl.raddr = AW'(a_q + PW'(len_q));
				state_d       = lbs_pkg::S_DEL_WR;
			end
			lbs_pkg::S_DEL_WR: begin
				ram_ctl.we = 1'b1;
				state_d = ((a_q + PW'(1) + PW'(len_q)) >= end_pos) ? lbs_pkg::S_DONE
				        : lbs_pkg::S_DEL_RD;
			end
			lbs_pkg::S_IDX_WALK: begin
				if (k_q == BW'(NB)) begin
					state_d = lbs_pkg::S_DONE;
				end else if (rem_q < cnt_q[k_q[BW-1:0]]) begin
					state_d = lbs_pkg::S_IDX_RD;
				end
			end
			lbs_pkg::S_IDX_RD: begin
				ram_ctl.raddr = AW'(p_q + PW'(i_q));
				state_d       = lbs_pkg::S_IDX_CAP;
			end
			lbs_pkg::S_IDX_CAP: begin
				state_d = (i_q == len_m1) ? lbs_pkg::S_DONE : lbs_pkg::S_IDX_RD;
			end
			lbs_pkg::S_DONE: begin
				if (out_free) begin
					state_d = lbs_pkg::S_IDLE;
				end
			end
			default: state_d = lbs_pkg::S_IDLE;
		endcase
	end

	// bucket table, counts and word total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= NB; k++) begin
				bs_q[k] <= PW'(lbs_pkg::HDR_BYTES);
			end
			for (int k = 0; k < NB; k++) begin
				cnt_q[k] <= '0;
			end
			total_q <= '0;
		end else begin
			if (in_fire && req_type == lbs_pkg::REQ_CLEAR) begin
				for (int k = 0; k <= NB; k++) begin
					bs_q[k] <= PW'(lbs_pkg::HDR_BYTES);
				end
				for (int k = 0; k < NB; k++) begin
					cnt_q[k] <= '0;
				end
				total_q <= '0;
			end
			if (state_q == lbs_pkg::S_PUT && i_q == len_m1) begin
				for (int k = 1; k <= NB; k++) begin
					if (BW'(k) > b_q) begin
						bs_q[k] <= bs_q[k] + PW'(len_q);
					end
				end
				cnt_q[b_q] <= cnt_q[b_q] + CW'(1);
				total_q    <= total_q + CW'(1);
			end
			// close the gap once the word has gone
			if ((state_q == lbs_pkg::S_DEL_WR && state_d == lbs_pkg::S_DONE)
			    || (state_q == lbs_pkg::S_FIND_CMP && req_q == lbs_pkg::REQ_REMOVE
			        && rdata == wbyte && i_q == len_m1
			        && (p_q + PW'(len_q)) >= end_pos)) begin
				for (int k = 1; k <= NB; k++) begin
					if (BW'(k) > b_q) begin
						bs_q[k] <= bs_q[k] - PW'(len_q);
					end
				end
				cnt_q[b_q] <= cnt_q[b_q] - CW'(1);
				total_q    <= total_q - CW'(1);
			end
		end
	end

	// request datapath
	always_ff @(posedge clk) begin
		case (state_q)
			lbs_pkg::S_IDLE: begin
				req_q  <= req_type;
				len_q  <= word_length;
				b_q    <= bs_idx;
				w_q    <= {chars_high, chars_mid, chars_low};
				rem_q  <= word_index;
				k_q    <= '0;
				i_q    <= '0;
				p_q    <= bs_rd;
				olen_q <= '0;
				oc_q   <= '0;
				st_q   <= (req_type <= lbs_pkg::REQ_CONTAINS && !len_ok) ? lbs_pkg::ST_BADLEN
				        : lbs_pkg::ST_OK;
			end
			lbs_pkg::S_LOAD_E: e_q <= bs_rd;
			lbs_pkg::S_FIND_RD: begin
				if (p_q >= e_q) begin
					a_q <= end_pos;
					i_q <= '0;
					if (req_q == lbs_pkg::REQ_ADD) begin
						if ((end_pos + PW'(len_q)) > PW'(lbs_pkg::STORE_BYTES)) begin
							st_q <= lbs_pkg::ST_FULL;
						end
					end else begin
						st_q <= lbs_pkg::ST_ABSENT;
					end
				end
			end
			lbs_pkg::S_FIND_CMP: begin
				if (rdata == wbyte) begin
					if (i_q == len_m1) begin
						a_q <= p_q;
					end else begin
						i_q <= i_q + 5'd1;
					end
				end else if (rdata > wbyte) begin
					a_q <= end_pos;
					i_q <= '0;
					if (req_q == lbs_pkg::REQ_ADD) begin
						if ((end_pos + PW'(len_q)) > PW'(lbs_pkg::STORE_BYTES)) begin
							st_q <= lbs_pkg::ST_FULL;
						end
					end else begin
						st_q <= lbs_pkg::ST_ABSENT;
					end
				end else begin
					p_q <= p_q + PW'(len_q);
					i_q <= '0;
				end
			end
			lbs_pkg::S_INS_WR: a_q <= a_q - PW'(1);
			lbs_pkg::S_PUT:    i_q <= i_q + 5'd1;
			lbs_pkg::S_DEL_WR: a_q <= a_q + PW'(1);
			lbs_pkg::S_IDX_WALK: begin
				if (k_q == BW'(NB)) begin
					st_q <= lbs_pkg::ST_ABSENT;
				end else if (rem_q < cnt_q[k_q]) begin
					p_q    <= bs_rd + PW'(rem_q * (5'(k_q) + 5'(lbs_pkg::MIN_WORD)));
					len_q  <= 5'(k_q) + 5'(lbs_pkg::MIN_WORD);
					olen_q <= 5'(k_q) + 5'(lbs_pkg::MIN_WORD);
					i_q    <= '0;
				end else begin
					rem_q <= rem_q - cnt_q[k_q];
					k_q   <= k_q + BW'(1);
				end
			end
			lbs_pkg::S_IDX_CAP: begin
				oc_q[{i_q, 3'b000} +: 8] <= rdata;
				i_q <= i_q + 5'd1;
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (state_q == lbs_pkg::S_DONE && out_free) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == lbs_pkg::S_DONE && out_free) begin
			status         <= st_q;
			out_length     <= (st_q == lbs_pkg::ST_OK) ? olen_q : 5'd0;
			out_chars_low  <= (st_q == lbs_pkg::ST_OK) ? oc_q[63:0] : 64'd0;
			out_chars_mid  <= (st_q == lbs_pkg::ST_OK) ? oc_q[127:64] : 64'd0;
			out_chars_high <= (st_q == lbs_pkg::ST_OK) ? oc_q[159:128] : 32'd0;
			word_total     <= total_q;
		end
	end

`ifndef SYNTHESIS
	a_first_bucket_fixed: assert property (@(posedge clk) disable iff (!arst_n)
		bs_q[0] == PW'(lbs_pkg::HDR_BYTES))
		else $error("first bucket start moved");
	a_end_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		bs_q[NB] <= PW'(lbs_pkg::STORE_BYTES))
		else $error("end of data past store");
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && req_type == lbs_pkg::REQ_CLEAR |=> total_q == '0)
		else $error("clear left words counted");
	a_fail_no_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != lbs_pkg::ST_OK |-> out_length == 5'd0)
		else $error("failed request returned a word");
`endif
endmodule
`default_nettype wire

/* sim/tb_length_bucketed_sorted_word_store_top.sv */
// Testbench for the length-bucketed sorted word store: predicts each result and checks it.
`timescale 1ns / 1ps
`default_nettype none
module tb_length_bucketed_sorted_word_store_top;

	class word_store_scoreboard;
		// predicted store, one queue of words per length bucket, each word as a 160-bit vector
		logic [lbs_pkg::CHAR_W-1:0] bucket_words[lbs_pkg::NBUCKETS][$];
		int                         used_bytes;
		logic [1:0]                 exp_status[$];
		logic [4:0]                 exp_length[$];
		logic [lbs_pkg::CHAR_W-1:0] exp_chars[$];
		logic [15:0]                exp_total[$];
		int                         errors;
		int                         checked;

		function void clear_store();
			for (int k = 0; k < lbs_pkg::NBUCKETS; k++)
				bucket_words[k].delete();
			used_bytes = lbs_pkg::HDR_BYTES;
		endfunction

		function int total_words();
			int t;
			t = 0;
			for (int k = 0; k < lbs_pkg::NBUCKETS; k++)
				t += bucket_words[k].size();
			return t;
		endfunction

		// byte-order compare: character 0 is most significant
		function int word_cmp(logic [lbs_pkg::CHAR_W-1:0] a, logic [lbs_pkg::CHAR_W-1:0] b,
				int len);
			for (int i = 0; i < len; i++) begin
				if (a[8*i +: 8] < b[8*i +: 8])
					return -1;
				if (a[8*i +: 8] > b[8*i +: 8])
					return 1;
			end
			return 0;
		endfunction

		function void note_request(logic [2:0] rq, logic [4:0] len,
				logic [lbs_pkg::CHAR_W-1:0] chars, logic [15:0] idx);
			logic [lbs_pkg::CHAR_W-1:0] w, oc;
			logic [1:0]                 st;
			logic [4:0]                 ol;
			bit                         len_ok, found;
			int                         b, pos, rem;
			w = '0;
			oc = '0;
			st = lbs_pkg::ST_OK;
			ol = '0;
			found = 0;
			pos = 0;
			len_ok = len >= lbs_pkg::MIN_WORD && len <= lbs_pkg::MAX_WORD;
			b = len_ok ? len - lbs_pkg::MIN_WORD : 0;
			for (int i = 0; i < len && i < 20; i++)
				w[8*i +: 8] = chars[8*i +: 8];
			if (len_ok) begin
				pos = bucket_words[b].size();
				for (int j = 0; j < bucket_words[b].size(); j++) begin
					int c;
					c = word_cmp(bucket_words[b][j], w, len);
					if (c == 0) begin
						found = 1;
						pos = j;
						break;
					end
					if (c > 0) begin
						pos = j;
						break;
					end
				end
			end
			if (rq <= lbs_pkg::REQ_CONTAINS && !len_ok)
				st = lbs_pkg::ST_BADLEN;
			else case (rq)
				lbs_pkg::REQ_ADD: begin
					if (!found) begin
						if (used_bytes + len > lbs_pkg::STORE_BYTES)
							st = lbs_pkg::ST_FULL;
						else begin
							bucket_words[b].insert(pos, w);
							used_bytes += len;
						end
					end
				end
				lbs_pkg::REQ_REMOVE: begin
					if (found) begin
						bucket_words[b].delete(pos);
						used_bytes -= len;
					end else
						st = lbs_pkg::ST_ABSENT;
				end
				lbs_pkg::REQ_CONTAINS: begin
					if (!found)
						st = lbs_pkg::ST_ABSENT;
				end
				lbs_pkg::REQ_INDEX: begin
					st = lbs_pkg::ST_ABSENT;
					rem = idx;
					for (int k = 0; k < lbs_pkg::NBUCKETS; k++) begin
						if (rem < bucket_words[k].size()) begin
							oc = bucket_words[k][rem];
							ol = 5'(k + lbs_pkg::MIN_WORD);
							st = lbs_pkg::ST_OK;
							break;
						end
						rem -= bucket_words[k].size();
					end
				end
				lbs_pkg::REQ_CLEAR: clear_store();
				default: ;
			endcase
			exp_status.push_back(st);
			exp_length.push_back(ol);
			exp_chars.push_back(oc);
			exp_total.push_back(16'(total_words()));
		endfunction

		function void check_result(logic [1:0] st, logic [4:0] ol,
				logic [lbs_pkg::CHAR_W-1:0] oc, logic [15:0] tot);
			logic [lbs_pkg::CHAR_W-1:0] ec;
			checked++;
			if (exp_status.size() == 0) begin
				$error("result with no request outstanding");
				errors++;
				return;
			end
			ec = exp_chars.pop_front();
			if (exp_status[0] !== st) begin
				$error("status: expected %0d, got %0d", exp_status[0], st);
				errors++;
			end
			if (exp_length[0] !== ol) begin
				$error("out_length: expected %0d, got %0d", exp_length[0], ol);
				errors++;
			end
			if (ec[63:0] !== oc[63:0]) begin
				$error("out_chars_low: expected %h, got %h", ec[63:0], oc[63:0]);
				errors++;
			end
			if (ec[127:64] !== oc[127:64]) begin
				$error("out_chars_mid: expected %h, got %h", ec[127:64], oc[127:64]);
				errors++;
			end
			if (ec[159:128] !== oc[159:128]) begin
				$error("out_chars_high: expected %h, got %h", ec[159:128], oc[159:128]);
				errors++;
			end
			if (exp_total[0] !== tot) begin
				$error("word_total: expected %0d, got %0d", exp_total[0], tot);
				errors++;
			end
			void'(exp_status.pop_front());
			void'(exp_length.pop_front());
			void'(exp_total.pop_front());
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_ready;
	logic [2:0]  req_type = 0;
	logic [4:0]  word_length = 0;
	logic [63:0] chars_low = 0;
	logic [63:0] chars_mid = 0;
	logic [31:0] chars_high = 0;
	logic [15:0] word_index = 0;
	logic        out_valid;
	logic        out_ready = 0;
	logic [1:0]  status;
	logic [4:0]  out_length;
	logic [63:0] out_chars_low;
	logic [63:0] out_chars_mid;
	logic [31:0] out_chars_high;
	logic [15:0] word_total;

	word_store_scoreboard sb;
	int  cycle_count = 0;
	bit  calm_phase = 0;   // no idling on either side
	bit  hold_results = 0; // long receiver hold-off
	int  accepted = 0;
	logic [lbs_pkg::CHAR_W-1:0] known_words[$];
	logic [4:0]                 known_lens[$];

	length_bucketed_sorted_word_store_top DUT (.*);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 2000000) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// check results at the rising edge
	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			sb.check_result(status, out_length, {out_chars_high, out_chars_mid, out_chars_low},
				word_total);

	// receiver: random stalls, none in calm phase, long hold-off on request
	always @(negedge clk) begin
		if (hold_results)
			out_ready <= 0;
		else if (calm_phase)
			out_ready <= 1;
		else
			out_ready <= ($urandom_range(99) >= 17);
	end

	// leaves valid high after acceptance; the next call drops or replaces the request
	task automatic send_request(logic [2:0] rq, logic [4:0] len,
			logic [lbs_pkg::CHAR_W-1:0] chars, logic [15:0] idx);
		if (!calm_phase)
			while ($urandom_range(99) < 17) begin
				in_valid <= 0;
				@(negedge clk);
			end
		in_valid    <= 1;
		req_type    <= rq;
		word_length <= len;
		chars_low   <= chars[63:0];
		chars_mid   <= chars[127:64];
		chars_high  <= chars[159:128];
		word_index  <= idx;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_request(rq, len, chars, idx);
		accepted++;
		@(negedge clk);
	endtask

	function automatic logic [lbs_pkg::CHAR_W-1:0] random_chars();
		logic [lbs_pkg::CHAR_W-1:0] c;
		for (int i = 0; i < 5; i++)
			c[32*i +: 32] = $urandom;
		return c;
	endfunction

	// a three-letter alphabet so that duplicates and hits are frequent
	function automatic logic [lbs_pkg::CHAR_W-1:0] narrow_chars();
		logic [lbs_pkg::CHAR_W-1:0] c;
		for (int i = 0; i < 20; i++)
			c[8*i +: 8] = 8'h61 + 8'($urandom_range(2));
		return c;
	endfunction

	task automatic add_known(logic [4:0] len, logic [lbs_pkg::CHAR_W-1:0] c);
		send_request(lbs_pkg::REQ_ADD, len, c, 16'd0);
		known_words.push_back(c);
		known_lens.push_back(len);
	endtask

	initial begin
		logic [lbs_pkg::CHAR_W-1:0] c;
		logic [4:0]                 len;
		int                         pick, r;
		sb = new();
		sb.clear_store();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: extremes, duplicates, bad lengths, all request codes
		add_known(5'(lbs_pkg::MIN_WORD), '0);
		add_known(5'(lbs_pkg::MAX_WORD), '1);
		add_known(5'(lbs_pkg::MIN_WORD), {lbs_pkg::CHAR_W{1'b1}});
		add_known(5'(lbs_pkg::MIN_WORD), '0);
		add_known(5'd5, {lbs_pkg::CHAR_W/8{8'h80}});
		add_known(5'd5, {lbs_pkg::CHAR_W/8{8'h7f}});
		send_request(lbs_pkg::REQ_ADD, 5'd0, random_chars(), 16'd0);
		send_request(lbs_pkg::REQ_ADD, 5'd1, random_chars(), 16'd0);
		send_request(lbs_pkg::REQ_ADD, 5'd21, random_chars(), 16'd0);
		send_request(lbs_pkg::REQ_REMOVE, 5'd31, random_chars(), 16'd0);
		send_request(lbs_pkg::REQ_CONTAINS, 5'd5, {lbs_pkg::CHAR_W/8{8'h7f}}, 16'd0);
		send_request(lbs_pkg::REQ_CONTAINS, 5'd5, {lbs_pkg::CHAR_W/8{8'h7e}}, 16'd0);
		for (int i = 0; i < 5; i++)
			send_request(lbs_pkg::REQ_INDEX, 5'd0, '0, 16'(i));
		send_request(lbs_pkg::REQ_INDEX, 5'd0, '0, 16'hffff);
		send_request(lbs_pkg::REQ_REMOVE, 5'd5, {lbs_pkg::CHAR_W/8{8'h80}}, 16'd0);
		send_request(lbs_pkg::REQ_REMOVE, 5'd5, {lbs_pkg::CHAR_W/8{8'h80}}, 16'd0);
		send_request(3'd5, 5'd7, random_chars(), 16'd0);
		send_request(3'd7, 5'd20, random_chars(), 16'hffff);
		send_request(lbs_pkg::REQ_CLEAR, 5'd3, '1, 16'hffff);
		send_request(lbs_pkg::REQ_INDEX, 5'd0, '0, 16'd0);
		known_words.delete();
		known_lens.delete();

		// random: mostly adds and lookups of a small vocabulary
		for (int n = 0; n < 70; n++) begin
			calm_phase = (n >= 40 && n < 60);
			r = $urandom_range(99);
			len = 5'($urandom_range(lbs_pkg::MIN_WORD, 6));
			if ($urandom_range(9) == 0)
				len = 5'($urandom_range(lbs_pkg::MIN_WORD, lbs_pkg::MAX_WORD));
			c = ($urandom_range(3) == 0) ? random_chars() : narrow_chars();
			if (r < 40)
				add_known(len, c);
			else if (r < 75 && known_words.size() > 0) begin
				pick = $urandom_range(known_words.size() - 1);
				send_request(r < 55 ? lbs_pkg::REQ_REMOVE : lbs_pkg::REQ_CONTAINS,
					known_lens[pick], known_words[pick], 16'd0);
			end else if (r < 82)
				send_request(3'($urandom_range(1, 2)), len, c, 16'd0);
			else if (r < 94)
				send_request(lbs_pkg::REQ_INDEX, 5'($urandom), random_chars(),
					16'($urandom_range(0, sb.total_words() + 2)));
			else if (r < 96)
				send_request(lbs_pkg::REQ_INDEX, 5'd0, '0, 16'($urandom));
			else if (r < 98)
				send_request(3'($urandom_range(0, 7)), 5'($urandom), random_chars(),
					16'($urandom));
			else begin
				send_request(lbs_pkg::REQ_CLEAR, 5'd0, '0, 16'd0);
				known_words.delete();
				known_lens.delete();
			end
		end

		// hold results back while requests keep coming
		fork
			begin
				hold_results = 1;
				repeat (3000) @(posedge clk);
				hold_results = 0;
			end
			begin
				for (int i = 0; i < 6; i++)
					send_request(lbs_pkg::REQ_INDEX, 5'd0, '0, 16'(i));
				in_valid <= 0;
			end
		join

		while (sb.exp_status.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		$display("Sent %0d requests, checked %0d results; %0d words left in store.",
			accepted, sb.checked, sb.total_words());
		if (sb.errors == 0 && sb.exp_status.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
`default_nettype wire

/* length_bucketed_sorted_word_store_top.f */
rtl/lbs_pkg.sv
rtl/lbs_byte_ram.sv
rtl/length_bucketed_sorted_word_store_top.sv
sim/tb_length_bucketed_sorted_word_store_top.sv
